@@ hdl/sidl_pkg.sv @@
// Package for the sorted id list merge unit: sizes, codes and transaction types.
package sidl_pkg;

    localparam int LIST_DEPTH = 1024;
    localparam int ID_WIDTH   = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_CLEAR    = 2'd0,
        FUNC_APPEND_A = 2'd1,
        FUNC_APPEND_B = 2'd2,
        FUNC_FETCH    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_ORDER = 2'd2
    } status_t;

    localparam logic MODE_INTERSECT = 1'b0;
    localparam logic MODE_UNION     = 1'b1;

    typedef struct packed {
        logic [1:0]          func;
        logic [ID_WIDTH-1:0] doc_id;
    } in_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0] result_id;
        logic                result_valid;
        logic                result_done;
        logic [1:0]          status;
    } out_t;

endpackage

@@ hdl/sorted_id_list_merge_unit.sv @@
// Top level of the sorted id list merge unit: command decode, merge walk, result register.
//
// Usage
//   s_valid/s_ready/s_data carry command transactions: clear both lists,
//   append an id to list A or list B, or fetch the next merged id.
//   m_valid/m_ready/m_data carry one result transaction per command.
//   cfg_valid/cfg_ready/cfg_data write merge_mode (0 intersect, 1 union);
//   write it only while no command is outstanding. cfg_ready is always high.
// Timing
//   Clear and append: the result enters the output register at the accept
//   edge if it is free; one command per cycle while m_ready is high.
//   Fetch: the list RAM read of both heads, then one compare per cycle.
//   Intersect fetches skip non-matching ids one compare at a time. The
//   walk is bound by the single read port of each list RAM (registered
//   read data).
// Reset
//   aresetn (synchronous, active low) empties both lists, zeros the read
//   positions and last ids, selects intersect mode and drops m_valid.
//   List RAM contents are not cleared; only entries below the count are read.
// Stall
//   A finished result sits in the output register while m_ready is low.
//   The next command is still accepted; when its result is ready and the
//   output register is still full, it parks in a hold register and
//   s_ready stays low until the pending result is taken.
module sorted_id_list_merge_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sidl_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sidl_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data
);

    // one-hot sequencer
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,   // waiting for a command
        ST_CMP  = 3'b010,   // RAM heads valid, compare and advance
        ST_DLV  = 3'b100    // result parked, output register busy
    } state_t;

    state_t state_reg, state_next;

    logic [sidl_pkg::CNT_W-1:0]    cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [sidl_pkg::CNT_W-1:0]    pos_a_reg, pos_a_next, pos_b_reg, pos_b_next;
    logic [sidl_pkg::ID_WIDTH-1:0] last_a_reg, last_a_next, last_b_reg, last_b_next;
    logic                          mode_reg;

    sidl_pkg::out_t res_reg;      // parked result
    sidl_pkg::out_t res_comb;     // result finished this cycle
    sidl_pkg::out_t out_val;
    logic           fin, out_load, hold_load, out_free;

    logic                          m_valid_reg;
    sidl_pkg::out_t                m_data_reg;

    // RAM ports
    logic                          wr_en_a, wr_en_b, rd_en;
    logic [sidl_pkg::ID_WIDTH-1:0] rd_a, rd_b;

    logic have_a, have_b;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    assign have_a = (pos_a_reg < cnt_a_reg);
    assign have_b = (pos_b_reg < cnt_b_reg);

    always_comb begin
        state_next  = state_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        pos_a_next  = pos_a_reg;
        pos_b_next  = pos_b_reg;
        last_a_next = last_a_reg;
        last_b_next = last_b_reg;
        res_comb    = '0;
        fin         = 1'b0;
        rd_en       = 1'b0;
        wr_en_a     = 1'b0;
        wr_en_b     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (sidl_pkg::func_t'(s_data.func))
                        sidl_pkg::FUNC_CLEAR: begin
                            cnt_a_next  = '0;
                            cnt_b_next  = '0;
                            pos_a_next  = '0;
                            pos_b_next  = '0;
                            last_a_next = '0;
                            last_b_next = '0;
                            fin         = 1'b1;
                        end
                        sidl_pkg::FUNC_APPEND_A: begin
                            fin = 1'b1;
                            if (cnt_a_reg >= sidl_pkg::CNT_W'(sidl_pkg::LIST_DEPTH)) begin
                                res_comb.status = sidl_pkg::STAT_FULL;
                            end else if (cnt_a_reg != '0 && s_data.doc_id <= last_a_reg) begin
                                res_comb.status = sidl_pkg::STAT_ORDER;
                            end else begin
                                wr_en_a     = 1'b1;
                                cnt_a_next  = cnt_a_reg + 1'b1;
                                last_a_next = s_data.doc_id;
                            end
                        end
                        sidl_pkg::FUNC_APPEND_B: begin
                            fin = 1'b1;
                            if (cnt_b_reg >= sidl_pkg::CNT_W'(sidl_pkg::LIST_DEPTH)) begin
                                res_comb.status = sidl_pkg::STAT_FULL;
                            end else if (cnt_b_reg != '0 && s_data.doc_id <= last_b_reg) begin
                                res_comb.status = sidl_pkg::STAT_ORDER;
                            end else begin
                                wr_en_b     = 1'b1;
                                cnt_b_next  = cnt_b_reg + 1'b1;
                                last_b_next = s_data.doc_id;
                            end
                        end
                        sidl_pkg::FUNC_FETCH: begin
                            // read both heads; compare next cycle
                            rd_en      = 1'b1;
                            state_next = ST_CMP;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_CMP: begin
                if (have_a && have_b) begin
                    if (rd_a == rd_b) begin
                        pos_a_next             = pos_a_reg + 1'b1;
                        pos_b_next             = pos_b_reg + 1'b1;
                        res_comb.result_id     = rd_a;
                        res_comb.result_valid  = 1'b1;
                        fin                    = 1'b1;
                    end else if (rd_a < rd_b) begin
                        pos_a_next = pos_a_reg + 1'b1;
                        if (mode_reg == sidl_pkg::MODE_UNION) begin
                            res_comb.result_id    = rd_a;
                            res_comb.result_valid = 1'b1;
                            fin                   = 1'b1;
                        end else begin
                            rd_en = 1'b1;   // skip, fetch next A head
                        end
                    end else begin
                        pos_b_next = pos_b_reg + 1'b1;
                        if (mode_reg == sidl_pkg::MODE_UNION) begin
                            res_comb.result_id    = rd_b;
                            res_comb.result_valid = 1'b1;
                            fin                   = 1'b1;
                        end else begin
                            rd_en = 1'b1;   // skip, fetch next B head
                        end
                    end
                end else if (mode_reg == sidl_pkg::MODE_UNION && have_a) begin
                    pos_a_next            = pos_a_reg + 1'b1;
                    res_comb.result_id    = rd_a;
                    res_comb.result_valid = 1'b1;
                    fin                   = 1'b1;
                end else if (mode_reg == sidl_pkg::MODE_UNION && have_b) begin
                    pos_b_next            = pos_b_reg + 1'b1;
                    res_comb.result_id    = rd_b;
                    res_comb.result_valid = 1'b1;
                    fin                   = 1'b1;
                end else begin
                    res_comb.result_done = 1'b1;
                    fin                  = 1'b1;
                end
            end
            ST_DLV: begin
                // parked result drains below
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // result routing: straight to output register, or park it
        out_load  = 1'b0;
        hold_load = 1'b0;
        out_val   = res_comb;
        if (state_reg == ST_DLV) begin
            out_val = res_reg;
            if (out_free) begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
        end else if (fin) begin
            if (out_free) begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end else begin
                hold_load  = 1'b1;
                state_next = ST_DLV;
            end
        end
    end

    sidl_list_ram u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_en_a),
        .wr_addr (cnt_a_reg[sidl_pkg::ADDR_W-1:0]),
        .wr_data (s_data.doc_id),
        .rd_en   (rd_en),
        .rd_addr (pos_a_next[sidl_pkg::ADDR_W-1:0]),
        .rd_data (rd_a)
    );

    sidl_list_ram u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_en_b),
        .wr_addr (cnt_b_reg[sidl_pkg::ADDR_W-1:0]),
        .wr_data (s_data.doc_id),
        .rd_en   (rd_en),
        .rd_addr (pos_b_next[sidl_pkg::ADDR_W-1:0]),
        .rd_data (rd_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            pos_a_reg   <= '0;
            pos_b_reg   <= '0;
            last_a_reg  <= '0;
            last_b_reg  <= '0;
            mode_reg    <= sidl_pkg::MODE_INTERSECT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_a_reg  <= cnt_a_next;
            cnt_b_reg  <= cnt_b_next;
            pos_a_reg  <= pos_a_next;
            pos_b_reg  <= pos_b_next;
            last_a_reg <= last_a_next;
            last_b_reg <= last_b_next;
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_val;
        end
        if (hold_load) begin
            res_reg <= res_comb;
        end
    end

endmodule

@@ hdl/sidl_list_ram.sv @@
// One list store: simple dual-port RAM, one write and one registered read port.
module sidl_list_ram (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [sidl_pkg::ADDR_W-1:0] wr_addr,
    input  logic [sidl_pkg::ID_WIDTH-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [sidl_pkg::ADDR_W-1:0] rd_addr,
    output logic [sidl_pkg::ID_WIDTH-1:0] rd_data
);

    logic [sidl_pkg::ID_WIDTH-1:0] mem [sidl_pkg::LIST_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/sidl_checker.sv @@
// Port-level checker for the sorted id list merge unit, bound to the top level.
module sidl_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input sidl_pkg::out_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a refused append carries no id, valid or done
    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != sidl_pkg::STAT_OK |->
            !m_data.result_valid && !m_data.result_done && m_data.result_id == '0)
        else $error("refused append carries fetch fields");

    // delivered and exhausted are exclusive, and no id without delivery
    a_valid_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.result_valid |-> m_data.result_id == '0)
        else $error("id present without result_valid");

    a_not_both: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.result_valid && m_data.result_done))
        else $error("result_valid and result_done both set");

    // nothing leaves the block right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind sorted_id_list_merge_unit sidl_checker u_sidl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ verif/sorted_id_list_merge_unit_test.sv @@
// Self-checking testbench for the sorted id list merge unit with a predictor and random streams.
`timescale 1ns / 100ps

module sorted_id_list_merge_unit_test;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    sidl_pkg::in_t   s_data;
    logic            m_valid;
    logic            m_ready;
    sidl_pkg::out_t  m_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic            cfg_data;

    sorted_id_list_merge_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: shadow copy of both lists, their counts, read
    // positions, last appended ids and the merge mode.
    // ------------------------------------------------------------------
    logic [sidl_pkg::ID_WIDTH-1:0] shadow_list_a [sidl_pkg::LIST_DEPTH];
    logic [sidl_pkg::ID_WIDTH-1:0] shadow_list_b [sidl_pkg::LIST_DEPTH];
    int unsigned                   len_a    = 0;
    int unsigned                   len_b    = 0;
    int unsigned                   rd_a     = 0;
    int unsigned                   rd_b     = 0;
    logic [sidl_pkg::ID_WIDTH-1:0] tail_a   = '0;
    logic [sidl_pkg::ID_WIDTH-1:0] tail_b   = '0;
    logic                          mode_now = sidl_pkg::MODE_INTERSECT;

    // Results predicted for accepted commands, oldest first.
    sidl_pkg::out_t merge_out_q [$];
    int             merge_out_owed = 0;
    int             mismatches     = 0;
    int unsigned    cmds_sent      = 0;

    // Shared knobs: quiet turns idling off on both sides, hold_off_cycles
    // asks the result sink for one long stall.
    bit          quiet           = 1'b0;
    int unsigned hold_off_cycles = 0;

    // Ascending id walker used to build well-formed lists.
    logic [sidl_pkg::ID_WIDTH-1:0] id_walk = '0;

    // Append with the same refusal order as the block: full first, then order.
    function automatic sidl_pkg::status_t append_id(bit to_b,
                                                    logic [sidl_pkg::ID_WIDTH-1:0] id);
        if (!to_b) begin
            if (len_a >= sidl_pkg::LIST_DEPTH) return sidl_pkg::STAT_FULL;
            if (len_a > 0 && id <= tail_a) return sidl_pkg::STAT_ORDER;
            shadow_list_a[len_a] = id;
            len_a++;
            tail_a = id;
        end else begin
            if (len_b >= sidl_pkg::LIST_DEPTH) return sidl_pkg::STAT_FULL;
            if (len_b > 0 && id <= tail_b) return sidl_pkg::STAT_ORDER;
            shadow_list_b[len_b] = id;
            len_b++;
            tail_b = id;
        end
        return sidl_pkg::STAT_OK;
    endfunction

    // Whole merge walk in one call; the block spreads it over cycles.
    function automatic bit walk_to_next(output logic [sidl_pkg::ID_WIDTH-1:0] id);
        logic [sidl_pkg::ID_WIDTH-1:0] a;
        logic [sidl_pkg::ID_WIDTH-1:0] b;
        id = '0;
        while (rd_a < len_a && rd_b < len_b) begin
            a = shadow_list_a[rd_a];
            b = shadow_list_b[rd_b];
            if (a == b) begin
                rd_a++;
                rd_b++;
                id = a;
                return 1'b1;
            end
            if (a < b) begin
                rd_a++;
                if (mode_now == sidl_pkg::MODE_UNION) begin
                    id = a;
                    return 1'b1;
                end
            end else begin
                rd_b++;
                if (mode_now == sidl_pkg::MODE_UNION) begin
                    id = b;
                    return 1'b1;
                end
            end
        end
        if (mode_now == sidl_pkg::MODE_INTERSECT) return 1'b0;
        // union: the tail of whichever list is left
        if (rd_a < len_a) begin
            id = shadow_list_a[rd_a];
            rd_a++;
            return 1'b1;
        end
        if (rd_b < len_b) begin
            id = shadow_list_b[rd_b];
            rd_b++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic sidl_pkg::out_t predict_merge_out(sidl_pkg::in_t cmd);
        sidl_pkg::out_t                r;
        logic [sidl_pkg::ID_WIDTH-1:0] id;
        r = '0;
        case (sidl_pkg::func_t'(cmd.func))
            sidl_pkg::FUNC_CLEAR: begin
                len_a  = 0;
                len_b  = 0;
                rd_a   = 0;
                rd_b   = 0;
                tail_a = '0;
                tail_b = '0;
            end
            sidl_pkg::FUNC_APPEND_A: r.status = append_id(1'b0, cmd.doc_id);
            sidl_pkg::FUNC_APPEND_B: r.status = append_id(1'b1, cmd.doc_id);
            default: begin
                if (walk_to_next(id)) begin
                    r.result_id    = id;
                    r.result_valid = 1'b1;
                end else begin
                    r.result_done = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: random stall before each transaction, or one long
    // hold-off when a test asks for it.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned gap;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_cycles > 0) begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 18);
            end
            if (gap > 0) begin
                @(negedge aclk) m_ready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every result transaction against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, sidl_pkg::out_t want, sidl_pkg::out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): exp id=%h v=%b d=%b st=%0d  got id=%h v=%b d=%b st=%0d",
                     $realtime, what, want.result_id, want.result_valid, want.result_done,
                     want.status, got.result_id, got.result_valid, got.result_done,
                     got.status);
    endtask

    always @(posedge aclk) begin : result_check
        sidl_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (merge_out_q.size() == 0) begin
                report_mismatch("unexpected", '0, m_data);
            end else begin
                want = merge_out_q.pop_front();
                merge_out_owed--;
                if (m_data.result_id !== want.result_id ||
                    m_data.result_valid !== want.result_valid ||
                    m_data.result_done !== want.result_done ||
                    m_data.status !== want.status)
                    report_mismatch("field", want, m_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Command driver and idle helpers
    // ------------------------------------------------------------------
    // Drive one command transaction; predict its result once accepted.
    task automatic send_cmd(sidl_pkg::func_t f, logic [sidl_pkg::ID_WIDTH-1:0] id);
        int unsigned   gap;
        sidl_pkg::in_t cmd;
        gap        = quiet ? 0 : $urandom_range(0, 18);
        cmd.func   = f;
        cmd.doc_id = id;
        if (gap > 0) begin
            @(negedge aclk) s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = cmd;
        do @(posedge aclk); while (!s_ready);
        merge_out_q.push_back(predict_merge_out(cmd));
        merge_out_owed++;
        cmds_sent++;
    endtask

    // Drop valid, wait for every owed result, then a short settle.
    task automatic wait_idle();
        @(negedge aclk) s_valid = 1'b0;
        wait (merge_out_owed == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_merge_mode(logic mode_v);
        wait_idle();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = mode_v;
        do @(posedge aclk); while (!cfg_ready);
        mode_now = mode_v;
        @(negedge aclk) cfg_valid = 1'b0;
    endtask

    // Well-formed stream with random content: ascending appends to A, B
    // or both (shared ids give hits), fetches, some refused appends, rare
    // clears and random ids as noise.
    task automatic random_stream(int n);
        int unsigned r;
        int unsigned step;
        int unsigned which;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                step  = $urandom_range(1, 6);
                which = $urandom_range(0, 2);
                if ({1'b0, id_walk} + step > 33'h0_FFFF_FFFF) begin
                    // top of the id range: repeat the last id
                    send_cmd(sidl_pkg::FUNC_APPEND_A, id_walk);
                end else begin
                    id_walk = id_walk + step;
                    if (which != 1) send_cmd(sidl_pkg::FUNC_APPEND_A, id_walk);
                    if (which != 0) send_cmd(sidl_pkg::FUNC_APPEND_B, id_walk);
                end
            end else if (r < 90) begin
                send_cmd(sidl_pkg::FUNC_FETCH, $urandom());
            end else if (r < 96) begin
                send_cmd($urandom_range(0, 1) ? sidl_pkg::FUNC_APPEND_A
                                              : sidl_pkg::FUNC_APPEND_B,
                         id_walk - $urandom_range(0, 3));
            end else if (r < 98) begin
                send_cmd($urandom_range(0, 1) ? sidl_pkg::FUNC_APPEND_A
                                              : sidl_pkg::FUNC_APPEND_B,
                         $urandom());
            end else begin
                send_cmd(sidl_pkg::FUNC_CLEAR, $urandom());
                id_walk = $urandom() >> $urandom_range(0, 31);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Intersect mode out of reset: empty fetch, order refusals, id extremes.
    task automatic test_intersect_basics();
        send_cmd(sidl_pkg::FUNC_FETCH, 32'hFFFF_FFFF);
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'h0000_0000);   // first id may be zero
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'h0000_0000);   // equal to last
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'h0000_0005);
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'h0000_0003);   // below last
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'hFFFF_FFFF);
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'hFFFF_FFFF);
        send_cmd(sidl_pkg::FUNC_APPEND_B, 32'h0000_0005);
        send_cmd(sidl_pkg::FUNC_APPEND_B, 32'hFFFF_FFFF);
        send_cmd(sidl_pkg::FUNC_APPEND_B, 32'h0000_0007);
        repeat (4) send_cmd(sidl_pkg::FUNC_FETCH, 32'h0000_0000);  // hits, then done twice
    endtask

    // Union: smaller head first, shared id once, live appends, mode flip mid-merge.
    task automatic test_union_basics();
        write_merge_mode(sidl_pkg::MODE_UNION);
        send_cmd(sidl_pkg::FUNC_CLEAR, 32'hA5A5_5A5A);
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'd1);
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'd3);
        send_cmd(sidl_pkg::FUNC_APPEND_B, 32'd2);
        send_cmd(sidl_pkg::FUNC_APPEND_B, 32'd3);
        repeat (5) send_cmd(sidl_pkg::FUNC_FETCH, 32'd0);
        send_cmd(sidl_pkg::FUNC_APPEND_B, 32'd9);
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'd4);
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'd9);
        send_cmd(sidl_pkg::FUNC_FETCH, 32'd0);
        write_merge_mode(sidl_pkg::MODE_INTERSECT);
        repeat (2) send_cmd(sidl_pkg::FUNC_FETCH, 32'd0);
    endtask

    // Fill list A to the last entry, then appends are refused as full.
    task automatic test_list_full();
        quiet = 1'b1;
        write_merge_mode(sidl_pkg::MODE_UNION);
        send_cmd(sidl_pkg::FUNC_CLEAR, 32'd0);
        for (int i = 0; i < sidl_pkg::LIST_DEPTH; i++)
            send_cmd(sidl_pkg::FUNC_APPEND_A, i * 32'h003F_FFFF + 1);
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'hFFFF_FFFF);
        send_cmd(sidl_pkg::FUNC_APPEND_A, 32'h0000_0000);
        send_cmd(sidl_pkg::FUNC_APPEND_B, 32'h0040_0000);
        repeat (6) send_cmd(sidl_pkg::FUNC_FETCH, 32'd0);
        send_cmd(sidl_pkg::FUNC_CLEAR, 32'd0);
        quiet = 1'b0;
    endtask

    // Long sink stall while commands keep coming: input must back up.
    task automatic test_output_backpressure();
        write_merge_mode(sidl_pkg::MODE_INTERSECT);
        send_cmd(sidl_pkg::FUNC_CLEAR, 32'd0);
        id_walk = 32'h1000_0000;
        quiet = 1'b1;
        hold_off_cycles = 300;
        random_stream(40);
        quiet = 1'b0;
    endtask

    // Random streams, new mode between streams, some streams on top of
    // the lists left by the previous one.
    task automatic test_random_merges();
        int unsigned target;
        target = cmds_sent + 700;
        while (cmds_sent < target) begin
            write_merge_mode(1'($urandom_range(0, 1)));
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0) begin
                send_cmd(sidl_pkg::FUNC_CLEAR, $urandom());
                id_walk = $urandom() >> $urandom_range(0, 31);
            end
            random_stream($urandom_range(10, 60));
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        test_intersect_basics();
        test_union_basics();
        test_list_full();
        test_output_backpressure();
        test_random_merges();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && merge_out_owed == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/sidl_pkg.sv
hdl/sidl_list_ram.sv
hdl/sorted_id_list_merge_unit.sv
hdl/sidl_checker.sv
verif/sorted_id_list_merge_unit_test.sv
